/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/rsq_pkg.sv */
package rsq_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int RANGE_W = 11;
    localparam int ALT_W   = 10;
    localparam int OSUM_W  = 13;
    localparam int CNT_W   = 8;
    localparam int Q16_W   = 16;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONS_HIGH    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 8'd3;

    localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = 32'd100000;
    localparam logic [ALT_W-1:0]  MAX_RANGE_RST    = 10'd300;
    localparam logic [Q16_W-1:0]  CONS_HIGH_RST    = 16'd52429;
    localparam logic [Q16_W-1:0]  ALPHA_RST        = 16'd11338;

    // Qualification constants
    localparam int ACCEPT_CM    = 50;
    localparam int MIN_RANGE_CM = 5;
    localparam int TAKEOFF_LO   = 20;
    localparam int TAKEOFF_HI   = 60;
    localparam int SHORTCUT_RUN = 4;
    localparam int TAKEOFF_RUN  = 2;

    // Controls for the consistency update
    typedef struct packed {
        logic present;
        logic good;
        logic shortcut;
    } cons_ctrl_t;

endpackage

/* rtl/core/range_sample_qualifier_unit.sv */
// Range sample qualifier.
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser, results leave on
// m_tvalid/m_tready/m_tdata/m_tuser, configuration writes on cfg_valid/cfg_ready.
// An item passes an input register, then the update logic (interval gate,
// range check, outlier test against the window mean, counters and the
// consistency average with its 16x17 multiplier) writes the state and the
// result register together; the result register drives m_tvalid and may
// wait behind a held result. One item per cycle is accepted and returned
// while the receiver keeps m_tready high. An item that comes sooner than the
// minimum interval after the last passed one yields no result.
// When m_tready is low the result register holds, the input register fills,
// and s_tready drops only when both are full; no item is lost or repeated.
// cfg_ready is always high; write registers only while the block is idle.
// aresetn (synchronous, active low) restores the default configuration and
// clears the window, counters, consistency and both pipeline stages.
`include "assert_macros.svh"

module range_sample_qualifier_unit #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_us[31:0], takeoff_active[32], range_cm[43:33], zero[47:44]
    input  logic [rsq_pkg::S_TDATA_W-1:0]    s_tdata,
    // sensor_present[0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // altitude_cm[9:0], window_sum[22:10], outlier_flag[23],
    // outlier_tally[31:24], consistency[47:32], delta_us[79:48]
    output logic [rsq_pkg::M_TDATA_W-1:0]    m_tdata,
    // reading_valid[0]
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rsq_pkg::*;

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = $clog2(WINDOW_LEN * 1023 + 1);
    localparam int CMP_W = $clog2((1023 + ACCEPT_CM) * WINDOW_LEN + 1);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Configuration
    logic [TIME_W-1:0] min_interval_reg;
    logic [ALT_W-1:0]  max_range_reg;
    logic [Q16_W-1:0]  cons_high_reg;
    logic [Q16_W-1:0]  alpha_reg;

    // Pipeline
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 in_user_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    // State
    logic [TIME_W-1:0] gate_time_reg;
    logic [ALT_W-1:0]  window_reg [WINDOW_LEN];
    logic [POS_W-1:0]  window_pos_reg, window_pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ALT_W-1:0]  alt_reg, alt_next;
    logic [CNT_W-1:0]  good_run_reg, good_run_next;
    logic [CNT_W-1:0]  takeoff_run_reg, takeoff_run_next;
    logic [CNT_W-1:0]  outlier_cnt_reg, outlier_cnt_next;
    logic              last_outlier_reg, last_outlier_next;
    logic [Q16_W-1:0]  cons_reg, cons_next;
    logic [TIME_W-1:0] last_valid_reg, last_valid_next;

    logic               adv;
    logic               proc;
    logic               pass;
    logic               upd;
    logic [TIME_W-1:0]  now_us;
    logic               takeoff_active;
    logic [RANGE_W-1:0] range_cm;
    logic               sensor_present;
    logic [ALT_W-1:0]   alt;
    logic               in_range;
    logic               reading_valid;
    logic               in_band;
    logic               outlier;
    logic [ALT_W-1:0]   old_entry;
    logic [TIME_W-1:0]  delta_next;
    cons_ctrl_t         cons_ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= MIN_INTERVAL_RST;
            max_range_reg    <= MAX_RANGE_RST;
            cons_high_reg    <= CONS_HIGH_RST;
            alpha_reg        <= ALPHA_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                CFG_MAX_RANGE:    max_range_reg    <= cfg_data[ALT_W-1:0];
                CFG_CONS_HIGH:    cons_high_reg    <= cfg_data[Q16_W-1:0];
                CFG_ALPHA:        alpha_reg        <= cfg_data[Q16_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees the update stage, which frees the input stage
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign proc     = in_valid_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser[0];
        end
    end

    assign now_us         = in_data_reg[31:0];
    assign takeoff_active = in_data_reg[32];
    assign range_cm       = in_data_reg[43:33];
    assign sensor_present = in_user_reg;
    assign alt            = range_cm[ALT_W-1:0];

    assign pass = (now_us - gate_time_reg) >= min_interval_reg;
    assign upd  = proc && pass;

    // Negative readings (no echo) fail on the sign bit
    assign in_range = !range_cm[RANGE_W-1]
                   && (alt >= ALT_W'(MIN_RANGE_CM))
                   && (alt <= max_range_reg);
    assign reading_valid = sensor_present && in_range;
    assign in_band = takeoff_active && (alt >= ALT_W'(TAKEOFF_LO))
                  && (alt <= ALT_W'(TAKEOFF_HI));

    assign old_entry = window_reg[window_pos_reg];

    // Compare against the mean without dividing: alt*N > sum + 50*N
    assign outlier = (CMP_W'(alt) * CMP_W'(WINDOW_LEN))
                   > (CMP_W'(sum_reg) + CMP_W'(ACCEPT_CM * WINDOW_LEN));

    always_comb begin
        window_pos_next   = window_pos_reg;
        sum_next          = sum_reg;
        alt_next          = alt_reg;
        good_run_next     = good_run_reg;
        takeoff_run_next  = takeoff_run_reg;
        outlier_cnt_next  = outlier_cnt_reg;
        last_outlier_next = last_outlier_reg;
        last_valid_next   = last_valid_reg;
        delta_next        = '0;
        cons_ctrl.present = sensor_present;
        cons_ctrl.good    = 1'b0;

        priority if (!sensor_present) begin
            sum_next        = '0;
            alt_next        = '0;
            last_valid_next = '0;
        end else if (reading_valid) begin
            alt_next         = alt;
            takeoff_run_next = in_band ? sat_inc(takeoff_run_reg) : '0;
            if (outlier) begin
                last_outlier_next = 1'b1;
                outlier_cnt_next  = sat_inc(outlier_cnt_reg);
                good_run_next     = '0;
            end else begin
                last_outlier_next = 1'b0;
                outlier_cnt_next  = (outlier_cnt_reg != '0) ? outlier_cnt_reg - 1'b1
                                                            : outlier_cnt_reg;
                good_run_next     = sat_inc(good_run_reg);
                cons_ctrl.good    = 1'b1;
            end
            sum_next        = sum_reg - SUM_W'(old_entry) + SUM_W'(alt);
            window_pos_next = (window_pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0
                            : window_pos_reg + 1'b1;
            delta_next      = now_us - last_valid_reg;
            last_valid_next = now_us;
        end else begin
            good_run_next = '0;
        end

        cons_ctrl.shortcut = (good_run_next >= CNT_W'(SHORTCUT_RUN))
                          || (takeoff_run_next >= CNT_W'(TAKEOFF_RUN));
    end

    rsq_consistency u_consistency (
        .cons_q    (cons_reg),
        .alpha     (alpha_reg),
        .cons_high (cons_high_reg),
        .ctrl      (cons_ctrl),
        .cons_next (cons_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_time_reg    <= '0;
            window_pos_reg   <= '0;
            sum_reg          <= '0;
            alt_reg          <= '0;
            good_run_reg     <= '0;
            takeoff_run_reg  <= '0;
            outlier_cnt_reg  <= '0;
            last_outlier_reg <= 1'b0;
            cons_reg         <= '0;
            last_valid_reg   <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window_reg[i] <= '0;
            end
        end else if (upd) begin
            gate_time_reg    <= now_us;
            window_pos_reg   <= window_pos_next;
            sum_reg          <= sum_next;
            alt_reg          <= alt_next;
            good_run_reg     <= good_run_next;
            takeoff_run_reg  <= takeoff_run_next;
            outlier_cnt_reg  <= outlier_cnt_next;
            last_outlier_reg <= last_outlier_next;
            cons_reg         <= cons_next;
            last_valid_reg   <= last_valid_next;
            if (!sensor_present) begin
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    window_reg[i] <= '0;
                end
            end else if (reading_valid) begin
                window_reg[window_pos_reg] <= alt;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            m_user_reg <= reading_valid;
            m_data_reg <= {delta_next, cons_next, outlier_cnt_next,
                           last_outlier_next, OSUM_W'(sum_next), alt_next};
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    `ASSERT_HOLDS(a_pos_in_window, aclk, aresetn, int'(window_pos_reg) < WINDOW_LEN)
    `ASSERT_HOLDS(a_run_not_outlier, aclk, aresetn, (good_run_reg == '0) || !last_outlier_reg)
    `ASSERT_NEXT(a_absent_clears, aclk, aresetn, upd && !sensor_present,
                 (cons_reg == '0) && (sum_reg == '0) && (alt_reg == '0))
    `ASSERT_NEXT(a_stall_holds_item, aclk, aresetn, in_valid_reg && !adv,
                 in_valid_reg && $stable(in_data_reg))

endmodule

/* rtl/core/rsq_consistency.sv */
module rsq_consistency (
    input  logic [rsq_pkg::Q16_W-1:0] cons_q,
    input  logic [rsq_pkg::Q16_W-1:0] alpha,
    input  logic [rsq_pkg::Q16_W-1:0] cons_high,
    input  rsq_pkg::cons_ctrl_t       ctrl,
    output logic [rsq_pkg::Q16_W-1:0] cons_next
);
    import rsq_pkg::*;

    logic [Q16_W:0]     keep_w;
    logic [2*Q16_W:0]   prod;
    logic [2*Q16_W+1:0] acc;
    logic [Q16_W+1:0]   rounded;
    logic [Q16_W-1:0]   avg;

    // c' = (c*(1-a) + g*a + 1/2) in Q0.16, rounded half up
    assign keep_w  = 17'h10000 - {1'b0, alpha};
    assign prod    = cons_q * keep_w;
    assign acc     = {1'b0, prod}
                   + (ctrl.good ? {2'b00, alpha, 16'h0000} : 34'd0)
                   + 34'd32768;
    assign rounded = acc[2*Q16_W+1:Q16_W];
    assign avg     = (rounded > 18'd65535) ? 16'hFFFF : rounded[Q16_W-1:0];

    always_comb begin
        priority if (!ctrl.present) begin
            cons_next = '0;
        end else if (ctrl.shortcut && (cons_q < cons_high)) begin
            cons_next = cons_high;
        end else begin
            cons_next = avg;
        end
    end

endmodule

/* sim/range_sample_qualifier_unit_tb.sv */
module range_sample_qualifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsq_pkg::*;

    localparam int WIN           = 5;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [TIME_W-1:0]  now_us;
        logic               present;
        logic               takeoff;
        logic [RANGE_W-1:0] range_cm;
    } sample_t;

    typedef struct {
        logic               reading_valid;
        logic [ALT_W-1:0]   altitude;
        logic [OSUM_W-1:0]  window_sum;
        logic               outlier_flag;
        logic [CNT_W-1:0]   outlier_tally;
        logic [Q16_W-1:0]   consistency;
        logic [TIME_W-1:0]  delta_us;
    } qual_result_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    class qualifier_scoreboard;
        logic [TIME_W-1:0] min_interval;
        logic [ALT_W-1:0]  max_range;
        logic [Q16_W-1:0]  cons_high;
        logic [Q16_W-1:0]  alpha;

        logic [TIME_W-1:0] gate_time;
        logic [ALT_W-1:0]  window[WIN];
        int unsigned       window_pos;
        int unsigned       window_total;
        logic [ALT_W-1:0]  altitude;
        int unsigned       good_run;
        int unsigned       takeoff_run;
        int unsigned       outlier_count;
        logic              last_outlier;
        logic [Q16_W-1:0]  cons;
        logic [TIME_W-1:0] last_valid_time;

        qual_result_t expected_q[$];
        int mismatches;
        int checked;
        int accepted;
        int dropped;
        int valid_seen;
        int outliers_seen;
        int absent_seen;

        function new();
            min_interval    = MIN_INTERVAL_RST;
            max_range       = MAX_RANGE_RST;
            cons_high       = CONS_HIGH_RST;
            alpha           = ALPHA_RST;
            gate_time       = '0;
            foreach (window[i]) window[i] = '0;
            window_pos      = 0;
            window_total    = 0;
            altitude        = '0;
            good_run        = 0;
            takeoff_run     = 0;
            outlier_count   = 0;
            last_outlier    = 1'b0;
            cons            = '0;
            last_valid_time = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_INTERVAL: min_interval = data;
                CFG_MAX_RANGE:    max_range    = data[ALT_W-1:0];
                CFG_CONS_HIGH:    cons_high    = data[Q16_W-1:0];
                CFG_ALPHA:        alpha        = data[Q16_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(sample_t s);
            qual_result_t     r;
            int               rng;
            bit               valid;
            bit               good;
            int unsigned      idx;
            longint unsigned  acc;
            logic [TIME_W-1:0] since;
            accepted++;
            since = s.now_us - gate_time;
            if (since < min_interval) begin
                dropped++;
                return;
            end
            gate_time = s.now_us;
            rng   = int'($signed(s.range_cm));
            valid = 1'b0;
            good  = 1'b0;
            r.delta_us = '0;
            if (!s.present) begin
                // drop the window and the figures built on it
                foreach (window[i]) window[i] = '0;
                window_total    = 0;
                altitude        = '0;
                cons            = '0;
                last_valid_time = '0;
                absent_seen++;
            end else begin
                if (rng >= MIN_RANGE_CM && rng <= int'(max_range)) begin
                    valid = 1'b1;
                    valid_seen++;
                    altitude = rng[ALT_W-1:0];
                    idx = (window_pos < WIN) ? window_pos : 0;
                    if (s.takeoff && rng >= TAKEOFF_LO && rng <= TAKEOFF_HI) begin
                        if (takeoff_run < 255) takeoff_run++;
                    end else begin
                        takeoff_run = 0;
                    end
                    // compare against the mean without dividing
                    if (rng * WIN > window_total + ACCEPT_CM * WIN) begin
                        last_outlier = 1'b1;
                        outliers_seen++;
                        if (outlier_count < 255) outlier_count++;
                        good_run = 0;
                    end else begin
                        last_outlier = 1'b0;
                        if (outlier_count > 0) outlier_count--;
                        good = 1'b1;
                        if (good_run < 255) good_run++;
                    end
                    window_total = window_total - 32'(window[idx]) + rng;
                    window[idx]  = rng[ALT_W-1:0];
                    window_pos   = (idx + 1 >= WIN) ? 0 : idx + 1;
                    r.delta_us      = s.now_us - last_valid_time;
                    last_valid_time = s.now_us;
                end else begin
                    good_run = 0;
                end
                if ((good_run >= SHORTCUT_RUN || takeoff_run >= TAKEOFF_RUN) &&
                        cons < cons_high) begin
                    cons = cons_high;
                end else begin
                    acc = 64'(cons) * (64'd65536 - 64'(alpha));
                    if (good) acc += 64'(alpha) << 16;
                    acc = (acc + 64'd32768) >> 16;
                    cons = (acc > 64'd65535) ? 16'hFFFF : acc[Q16_W-1:0];
                end
            end
            r.reading_valid = valid;
            r.altitude      = altitude;
            r.window_sum    = window_total[OSUM_W-1:0];
            r.outlier_flag  = last_outlier;
            r.outlier_tally = outlier_count[CNT_W-1:0];
            r.consistency   = cons;
            expected_q.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH result %0d %s: expected %0d (0x%h) got %0d (0x%h)",
                             checked, field, want, want, got, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            qual_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH result with nothing expected: tdata 0x%h tuser %b",
                             tdata, tuser);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare("reading_valid", 32'(e.reading_valid), 32'(tuser));
            compare("altitude_cm",   32'(e.altitude),      32'(tdata[9:0]));
            compare("window_sum",    32'(e.window_sum),    32'(tdata[22:10]));
            compare("outlier_flag",  32'(e.outlier_flag),  32'(tdata[23]));
            compare("outlier_tally", 32'(e.outlier_tally), 32'(tdata[31:24]));
            compare("consistency",   32'(e.consistency),   32'(tdata[47:32]));
            compare("delta_us",      e.delta_us,           tdata[79:48]);
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    qualifier_scoreboard sb;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       track_cm = 40;
    bit       takeoff_mode = 1'b0;

    range_sample_qualifier_unit #(
        .WINDOW_LEN(WIN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls in stretches of one pattern at a time
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_mode  <= RX_OPEN;
            rx_left  <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(16, 160);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (rx_left < 4);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    task automatic send_sample(sample_t s);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, s.range_cm, s.takeoff, s.now_us};
        s_tuser  <= s.present;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(s);
    endtask

    task automatic send_at(logic [TIME_W-1:0] step, bit present, bit takeoff, int range_val);
        sample_t s;
        s.now_us   = sb.gate_time + step;
        s.present  = present;
        s.takeoff  = takeoff;
        s.range_cm = range_val[RANGE_W-1:0];
        send_sample(s);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        // let a trailing dropped item clear the pipeline
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [31:0] interval, logic [31:0] top_cm,
                              logic [31:0] high, logic [31:0] factor);
        wait_idle();
        write_cfg(CFG_MIN_INTERVAL, interval);
        write_cfg(CFG_MAX_RANGE, top_cm);
        write_cfg(CFG_CONS_HIGH, high);
        write_cfg(CFG_ALPHA, factor);
        cfg_valid <= 1'b0;
    endtask

    // mostly pass the interval gate, sometimes fall just inside it or jump anywhere
    function automatic logic [TIME_W-1:0] next_stamp();
        logic [TIME_W-1:0] iv;
        logic [TIME_W-1:0] headroom;
        int                pick;
        iv       = sb.min_interval;
        headroom = 32'hFFFF_FFFF - iv;
        pick     = $urandom_range(0, 15);
        if (pick == 0) return $urandom;
        if (pick <= 2 && iv != 0) return sb.gate_time + $urandom_range(0, iv - 1);
        if (pick == 3) return sb.gate_time + iv + $urandom_range(0, headroom);
        return sb.gate_time + iv + $urandom_range(0, (headroom < 2000) ? headroom : 2000);
    endfunction

    // a slowly moving altitude track with outliers, dropouts and junk mixed in
    function automatic logic [RANGE_W-1:0] next_range();
        int top;
        int pick;
        int v;
        top  = int'(sb.max_range);
        pick = $urandom_range(0, 99);
        track_cm = track_cm + int'($urandom_range(0, 16)) - 8;
        if (track_cm > top) track_cm = top;
        if (track_cm < MIN_RANGE_CM) track_cm = MIN_RANGE_CM;
        if (pick < 4)
            v = -1;
        else if (pick < 7)
            v = -int'($urandom_range(1, 1024));
        else if (pick < 10)
            v = $urandom_range(0, MIN_RANGE_CM - 1);
        else if (pick < 13)
            v = (top < 1023) ? int'($urandom_range(top + 1, 1023)) : 1023;
        else if (pick < 21)
            v = track_cm + int'($urandom_range(ACCEPT_CM + 1, 300));
        else if (takeoff_mode)
            v = $urandom_range(TAKEOFF_LO - 2, TAKEOFF_HI + 2);
        else
            v = track_cm;
        if (v > 1023) v = 1023;
        return v[RANGE_W-1:0];
    endfunction

    task automatic run_random(int count);
        sample_t s;
        int      burst;
        burst = $urandom_range(1, 24);
        repeat (count) begin
            if ($urandom_range(0, 14) == 0) takeoff_mode = !takeoff_mode;
            s.now_us   = next_stamp();
            s.present  = ($urandom_range(0, 24) != 0);
            s.takeoff  = ($urandom_range(0, 9) == 0) ? !takeoff_mode : takeoff_mode;
            s.range_cm = next_range();
            send_sample(s);
            burst = burst - 1;
            if (burst == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 24);
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("range_sample_qualifier_unit verification failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: 100 ms gate, 300 cm ceiling
        send_at(32'd100000, 1'b1, 1'b0, 30);
        send_at(32'd99999,  1'b1, 1'b0, 40);   // one microsecond short of the gate
        send_at(32'd100000, 1'b1, 1'b0, 5);
        send_at(32'd100000, 1'b1, 1'b0, 4);
        send_at(32'd100000, 1'b1, 1'b0, 0);
        send_at(32'd100000, 1'b1, 1'b0, -1);   // no echo
        send_at(32'd100000, 1'b1, 1'b0, 300);
        send_at(32'd100000, 1'b1, 1'b0, 301);
        send_at(32'd100000, 1'b1, 1'b0, 1023);
        send_at(32'd100000, 1'b1, 1'b0, -1024);
        send_at(32'd100000, 1'b1, 1'b1, 19);
        send_at(32'd100000, 1'b1, 1'b1, 20);
        send_at(32'd100000, 1'b1, 1'b1, 60);
        send_at(32'd100000, 1'b1, 1'b1, 61);
        send_at(32'd100000, 1'b1, 1'b1, 40);
        send_at(32'd100000, 1'b1, 1'b1, 45);
        // invalid reading while the takeoff run is still held
        send_at(32'd100000, 1'b1, 1'b0, -1);
        send_at(32'd100000, 1'b1, 1'b0, 50);
        send_at(32'd100000, 1'b1, 1'b0, 55);
        send_at(32'd100000, 1'b1, 1'b0, 60);
        send_at(32'd100000, 1'b1, 1'b0, 58);
        send_at(32'd100000, 1'b1, 1'b0, 62);
        send_at(32'd100000, 1'b0, 1'b1, 1023);
        send_at(32'hFFFF_0000, 1'b0, 1'b0, -1); // timestamp wraps
        send_at(32'd100000, 1'b1, 1'b0, 100);

        run_random(80);
        wait_idle();
        run_random(70);

        set_config(32'd0, 32'd1023, 32'd65535, 32'd65535);
        run_random(100);

        // every reading out of range (ceiling below the floor), gate passes only one step short of a wrap
        set_config(32'hFFFF_FFFF, 32'd4, 32'd0, 32'd0);
        run_random(30);

        set_config(32'd1, 32'd5, 32'd1, 32'd1);
        run_random(40);

        set_config($urandom_range(1000, 200000), $urandom_range(100, 1023),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_random(150);

        set_config(32'(MIN_INTERVAL_RST), 32'(MAX_RANGE_RST), 32'(CONS_HIGH_RST),
                   32'(ALPHA_RST));
        run_random(50);

        wait_idle();
        $display("Sent %0d samples: %0d held back by the interval gate, %0d results checked",
                 sb.accepted, sb.dropped, sb.checked);
        $display("Saw %0d valid readings, %0d outliers, %0d sensor-absent samples over 6 setups",
                 sb.valid_seen, sb.outliers_seen, sb.absent_seen);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("range_sample_qualifier_unit verification clean");
        else
            $display("range_sample_qualifier_unit verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rsq_pkg.sv
rtl/core/rsq_consistency.sv
rtl/core/range_sample_qualifier_unit.sv
sim/range_sample_qualifier_unit_tb.sv
